@@ rtl/hpdt_pkg.sv @@
// hpdt_pkg: shared opcodes, constants and controller/datapath interface types
// for the hpack dynamic table manager; used by every module of the block
package hpdt_pkg;

	// item opcodes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_GET   = 2'd1;
	localparam logic [1:0] OP_LIMIT = 2'd2;

	// per-entry accounting overhead in bytes
	localparam int unsigned ENTRY_OVERHEAD = 32;
	// width of name length + value length + overhead
	localparam int unsigned ENTRY_SIZE_W = 18;

	// commands from controller to datapath
	typedef struct packed {
		logic load_item;
		logic set_limit;
		logic empty;
		logic rd_oldest;
		logic rd_get;
		logic evict;
		logic commit_add;
		logic load_result;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       too_big;
		logic       get_bad;
		logic       lim_zero;
		logic       need_evict;
	} dp_status_t;

endpackage

@@ rtl/hpdt_ctrl.sv @@
// hpdt_ctrl: sequencing state machine and output valid for the table manager
// depends on hpdt_pkg (command and status types, opcodes)
module hpdt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  hpdt_pkg::dp_status_t  st,
	output hpdt_pkg::dp_cmd_t     cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LOOK   = 2'd1;
	localparam logic [1:0] S_EVICT  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_LOOK;
				end
			end
			S_LOOK: begin
				case (st.op)
					hpdt_pkg::OP_ADD: begin
						if (st.too_big) begin
							cmd.empty = 1'b1;
							state_d   = S_FINISH;
						end else begin
							cmd.rd_oldest = 1'b1;
							state_d       = S_EVICT;
						end
					end
					hpdt_pkg::OP_GET: begin
						cmd.rd_get = !st.get_bad;
						state_d    = S_FINISH;
					end
					hpdt_pkg::OP_LIMIT: begin
						cmd.set_limit = 1'b1;
						if (st.lim_zero) begin
							cmd.empty = 1'b1;
							state_d   = S_FINISH;
						end else begin
							cmd.rd_oldest = 1'b1;
							state_d       = S_EVICT;
						end
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_EVICT: begin
				// one oldest entry leaves per cycle until the condition clears
				if (st.need_evict) begin
					cmd.evict = 1'b1;
				end else begin
					cmd.commit_add = (st.op == hpdt_pkg::OP_ADD);
					state_d        = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/hpdt_datapath.sv @@
// hpdt_datapath: slot length store, table pointers and byte accounting,
// result registers; depends on hpdt_pkg (command and status types, constants)
module hpdt_datapath #(
	parameter int unsigned MAX_TABLE_BYTES = 4096,
	parameter int unsigned SLOT_COUNT      = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hpdt_pkg::dp_cmd_t     cmd,
	output hpdt_pkg::dp_status_t  st,
	input  logic [1:0]            opcode,
	input  logic [15:0]           name_length,
	input  logic [15:0]           value_length,
	input  logic [7:0]            recency_index,
	input  logic [15:0]           new_limit,
	output logic                  status,
	output logic [6:0]            slot,
	output logic [15:0]           stored_name_bytes,
	output logic [15:0]           stored_value_bytes,
	output logic                  was_added,
	output logic [7:0]            evicted,
	output logic [7:0]            entry_count,
	output logic [12:0]           table_bytes
);

	localparam int unsigned SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned CNT_W   = $clog2(SLOT_COUNT + 1);
	localparam int unsigned BYTES_W = $clog2(MAX_TABLE_BYTES + 1);
	localparam int unsigned SZ_W    = hpdt_pkg::ENTRY_SIZE_W;
	localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
	localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(SLOT_COUNT);
	localparam logic [BYTES_W-1:0] LIMIT_MAX = BYTES_W'(MAX_TABLE_BYTES);

	// slot length store
	logic [15:0] name_mem  [SLOT_COUNT];
	logic [15:0] value_mem [SLOT_COUNT];
	logic [15:0] rd_name;
	logic [15:0] rd_value;

	// item registers
	logic [1:0]         op_q;
	logic [15:0]        nlen_q;
	logic [15:0]        vlen_q;
	logic [7:0]         idx_q;
	logic [BYTES_W-1:0] lim_q;

	// table state
	logic [SLOT_W-1:0]  oldest_q;
	logic [SLOT_W-1:0]  next_q;
	logic [CNT_W-1:0]   live_q;
	logic [BYTES_W-1:0] used_q;
	logic [BYTES_W-1:0] limit_q;

	// per-item bookkeeping
	logic [CNT_W-1:0]  ev_cnt_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              added_q;

	// result registers
	logic              status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [15:0]       name_q;
	logic [15:0]       value_q;
	logic              was_added_q;
	logic [CNT_W-1:0]  evicted_q;
	logic [CNT_W-1:0]  count_q;
	logic [BYTES_W-1:0] bytes_q;

	logic [SZ_W-1:0]    new_sz;
	logic [SZ_W-1:0]    old_sz;
	logic [31:0]        need;
	logic [31:0]        used_less;
	logic [SLOT_W-1:0]  oldest_wrap;
	logic [SLOT_W-1:0]  next_wrap;
	logic [SLOT_W-1:0]  get_slot;
	logic [31:0]        get_diff;
	logic [SLOT_W-1:0]  rd_addr;
	logic               rd_en;
	logic               good_get;
	logic [BYTES_W-1:0] lim_clamped;

	// entry sizes and clamped limit
	assign new_sz = SZ_W'(nlen_q) + SZ_W'(vlen_q) + SZ_W'(hpdt_pkg::ENTRY_OVERHEAD);
	assign old_sz = SZ_W'(rd_name) + SZ_W'(rd_value) + SZ_W'(hpdt_pkg::ENTRY_OVERHEAD);
	assign lim_clamped = (32'(new_limit) > 32'(MAX_TABLE_BYTES)) ? LIMIT_MAX
		: BYTES_W'(new_limit);
	assign need = (op_q == hpdt_pkg::OP_ADD) ? 32'(new_sz) : 32'd0;
	assign used_less = (32'(used_q) >= 32'(old_sz)) ? 32'(used_q) - 32'(old_sz) : 32'd0;

	// circular pointer steps
	assign oldest_wrap = (oldest_q == SLOT_LAST) ? '0 : oldest_q + SLOT_W'(1);
	assign next_wrap   = (next_q == SLOT_LAST) ? '0 : next_q + SLOT_W'(1);

	// slot of the idx-th newest entry
	assign get_diff = (32'(next_q) >= 32'(idx_q))
		? 32'(next_q) - 32'(idx_q)
		: 32'(next_q) + 32'(SLOT_COUNT) - 32'(idx_q);
	assign get_slot = get_diff[SLOT_W-1:0];

	// status toward the controller
	always_comb begin
		st.op         = op_q;
		st.too_big    = 32'(new_sz) > 32'(limit_q);
		st.get_bad    = (idx_q == 8'd0) || (32'(idx_q) > 32'(live_q));
		st.lim_zero   = (lim_q == '0);
		st.need_evict = (live_q != '0) &&
			((32'(used_q) + need > 32'(limit_q)) ||
			 ((op_q == hpdt_pkg::OP_ADD) && (live_q == CNT_FULL)));
	end

	assign good_get = (op_q == hpdt_pkg::OP_GET) && !st.get_bad;

	// read address select
	always_comb begin
		rd_en   = cmd.rd_oldest | cmd.evict | cmd.rd_get;
		rd_addr = oldest_q;
		if (cmd.evict) begin
			rd_addr = oldest_wrap;
		end else if (cmd.rd_get) begin
			rd_addr = get_slot;
		end
	end

	// length store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit_add) begin
			name_mem[next_q]  <= nlen_q;
			value_mem[next_q] <= vlen_q;
		end
		if (rd_en) begin
			rd_name  <= name_mem[rd_addr];
			rd_value <= value_mem[rd_addr];
		end
	end

	// captured item fields
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= opcode;
			nlen_q <= name_length;
			vlen_q <= value_length;
			idx_q  <= recency_index;
			lim_q  <= lim_clamped;
		end
	end

	// table pointers, count, bytes and limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q   <= '0;
			next_q     <= '0;
			live_q     <= '0;
			used_q     <= '0;
			limit_q    <= LIMIT_MAX;
			ev_cnt_q   <= '0;
			res_slot_q <= '0;
			added_q    <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				ev_cnt_q   <= '0;
				res_slot_q <= '0;
				added_q    <= 1'b0;
			end
			if (cmd.set_limit) begin
				limit_q <= lim_q;
			end
			if (cmd.empty) begin
				oldest_q <= '0;
				next_q   <= '0;
				live_q   <= '0;
				used_q   <= '0;
				ev_cnt_q <= live_q;
			end
			if (cmd.rd_get) begin
				res_slot_q <= get_slot;
			end
			if (cmd.evict) begin
				oldest_q <= oldest_wrap;
				live_q   <= live_q - CNT_W'(1);
				used_q   <= used_less[BYTES_W-1:0];
				ev_cnt_q <= ev_cnt_q + CNT_W'(1);
			end
			if (cmd.commit_add) begin
				next_q     <= next_wrap;
				live_q     <= live_q + CNT_W'(1);
				used_q     <= used_q + BYTES_W'(new_sz);
				res_slot_q <= next_q;
				added_q    <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			status_q    <= (op_q == hpdt_pkg::OP_GET) && st.get_bad;
			slot_q      <= res_slot_q;
			name_q      <= good_get ? rd_name : 16'd0;
			value_q     <= good_get ? rd_value : 16'd0;
			was_added_q <= added_q;
			evicted_q   <= ev_cnt_q;
			count_q     <= live_q;
			bytes_q     <= used_q;
		end
	end

	// fit results to port widths
	logic [31:0] slot_ext;
	logic [31:0] evicted_ext;
	logic [31:0] count_ext;
	logic [31:0] bytes_ext;

	assign slot_ext    = 32'(slot_q);
	assign evicted_ext = 32'(evicted_q);
	assign count_ext   = 32'(count_q);
	assign bytes_ext   = 32'(bytes_q);

	assign status             = status_q;
	assign slot               = slot_ext[6:0];
	assign stored_name_bytes  = name_q;
	assign stored_value_bytes = value_q;
	assign was_added          = was_added_q;
	assign evicted            = evicted_ext[7:0];
	assign entry_count        = count_ext[7:0];
	assign table_bytes        = bytes_ext[12:0];

endmodule

@@ rtl/hpack_dynamic_table_manager.sv @@
// HPACK dynamic table manager: keeps name and value lengths of the dynamic
// table in a circular store of SLOT_COUNT slots and accounts its byte size.
// Each item (add, get, set limit) is taken when the block is idle. An add or
// a nonzero set limit passes from acceptance through the look-up, eviction
// and finish states before the next item can be taken; the eviction walk
// reads one oldest slot per cycle from the single read port of the length
// store, and the result register is loaded in the finish state. A get, a
// zero limit, an add too large for the limit and an unused opcode skip the
// walk and go from look-up straight to finish. The next item is accepted
// while the previous result still waits in the output register; it then
// holds in its last step until that result is taken. No clearing pass is
// needed after reset. Depends on hpdt_pkg, hpdt_ctrl and hpdt_datapath.
module hpack_dynamic_table_manager #(
	parameter int unsigned MAX_TABLE_BYTES = 4096,
	parameter int unsigned SLOT_COUNT      = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] name_length,
	input  logic [15:0] value_length,
	input  logic [7:0]  recency_index,
	input  logic [15:0] new_limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [6:0]  slot,
	output logic [15:0] stored_name_bytes,
	output logic [15:0] stored_value_bytes,
	output logic        was_added,
	output logic [7:0]  evicted,
	output logic [7:0]  entry_count,
	output logic [12:0] table_bytes
);

	hpdt_pkg::dp_cmd_t    cmd;
	hpdt_pkg::dp_status_t st;

	// sequencing
	hpdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// table store and accounting
	hpdt_datapath #(
		.MAX_TABLE_BYTES (MAX_TABLE_BYTES),
		.SLOT_COUNT      (SLOT_COUNT)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.st                 (st),
		.opcode             (opcode),
		.name_length        (name_length),
		.value_length       (value_length),
		.recency_index      (recency_index),
		.new_limit          (new_limit),
		.status             (status),
		.slot               (slot),
		.stored_name_bytes  (stored_name_bytes),
		.stored_value_bytes (stored_value_bytes),
		.was_added          (was_added),
		.evicted            (evicted),
		.entry_count        (entry_count),
		.table_bytes        (table_bytes)
	);

endmodule
